// ===== design/nqfs_pkg.sv =====
// Shared constants and controller/datapath interface types for the
// n-queens first-solution search. No dependencies.
`default_nettype none

package nqfs_pkg;

    localparam int SIZE_W       = 5;   // board size field width
    localparam int OUT_W        = 4;   // row / column result field width
    localparam int MAX_SIZE_DEF = 16;  // default storage bound
    localparam int RESULT_LIMIT = 16;  // most result items one search may give

    // Commands from controller to datapath; at most one is active per cycle.
    typedef struct packed {
        logic start;       // latch size, clear masks and row
        logic place;       // keep the chosen column, advance a row
        logic back_rd;     // step back a row, fetch its column
        logic back_apply;  // lift that queen, resume one column to the right
        logic emit_rd;     // fetch the column for the next result item
        logic emit_ld;     // load a solved result item
        logic load_fail;   // load the single no-solution result item
    } t_dp_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic bad_size;    // incoming size is zero or beyond the limit
        logic row_full;    // every row holds a queen
        logic row_zero;    // search is at the top row
        logic found;       // a free column exists in the current row
        logic emit_last;   // result item being loaded is the final row
        logic out_free;    // output register can take an item this cycle
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== design/nqfs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module nqfs_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== design/nqfs_ctrl.sv =====
// Search controller: sequences placement, backtracking and readout.
// Uses nqfs_pkg command/status types.
`default_nettype none

module nqfs_ctrl
    import nqfs_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd,
    output logic          o_busy
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SCAN    = 3'd1;
    localparam logic [2:0] S_BACK_RD = 3'd2;
    localparam logic [2:0] S_BACK    = 3'd3;
    localparam logic [2:0] S_FAIL    = 3'd4;
    localparam logic [2:0] S_EMIT_RD = 3'd5;
    localparam logic [2:0] S_EMIT    = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = i_stat.bad_size ? S_FAIL : S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.row_full) begin
                    n_state = S_EMIT_RD;
                end else if (i_stat.found) begin
                    o_cmd.place = 1'b1;
                end else if (i_stat.row_zero) begin
                    n_state = S_FAIL;
                end else begin
                    o_cmd.back_rd = 1'b1;
                    n_state       = S_BACK_RD;
                end
            end
            // row stepped back last cycle; its column is read here, valid in S_BACK
            S_BACK_RD: begin
                n_state = S_BACK;
            end
            S_BACK: begin
                o_cmd.back_apply = 1'b1;
                n_state          = S_SCAN;
            end
            S_FAIL: begin
                if (i_stat.out_free) begin
                    o_cmd.load_fail = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_EMIT_RD: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_rd = 1'b1;
                    n_state       = S_EMIT;
                end
            end
            S_EMIT: begin
                o_cmd.emit_ld = 1'b1;
                n_state       = i_stat.emit_last ? S_IDLE : S_EMIT_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

// ===== design/nqfs_dp.sv =====
// Search datapath: occupancy masks, row/start registers, column store
// and output register. Uses nqfs_pkg and nqfs_ram.
`default_nettype none

module nqfs_dp
    import nqfs_pkg::*;
#(
    parameter int MAX_SIZE = MAX_SIZE_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_dp_cmd           i_cmd,
    output t_dp_stat               o_stat,
    input  wire logic [SIZE_W-1:0] i_board_size,
    input  wire logic              i_stall,
    output logic                   o_valid,
    output logic      [OUT_W-1:0]  o_row_index,
    output logic      [OUT_W-1:0]  o_queen_col,
    output logic                   o_solved,
    output logic                   o_last
);

    localparam int SIZE_LIMIT = (MAX_SIZE < RESULT_LIMIT) ? MAX_SIZE : RESULT_LIMIT;
    localparam int RW  = $clog2(MAX_SIZE + 1);
    localparam int CW  = $clog2(MAX_SIZE);
    localparam int DW  = 2 * MAX_SIZE - 1;
    localparam int DIW = $clog2(DW);

    logic [RW-1:0]       r_n;
    logic [RW-1:0]       r_row;
    logic [RW-1:0]       r_start;
    logic [CW-1:0]       r_k;
    logic [MAX_SIZE-1:0] r_col_taken;
    logic [DW-1:0]       r_down_taken;
    logic [DW-1:0]       r_up_taken;

    logic [MAX_SIZE-1:0] free_cols;
    logic [MAX_SIZE-1:0] lowest;
    logic [CW-1:0]       sel_col;
    logic [CW-1:0]       tgl_col;
    logic [DIW-1:0]      tgl_down;
    logic [DIW-1:0]      tgl_up;
    logic                toggle;
    logic [CW-1:0]       ram_raddr;
    logic [CW-1:0]       ram_rdata;

    // columns of the current row that are free and not yet tried
    always_comb begin
        logic [DIW-1:0] di;
        logic [DIW-1:0] ui;
        free_cols = '0;
        di        = '0;
        ui        = '0;
        if (r_row < r_n) begin
            for (int c = 0; c < MAX_SIZE; c++) begin
                if ((RW'(c) < r_n) && (RW'(c) >= r_start)) begin
                    di = DIW'(r_row) + DIW'(r_n) - DIW'(1) - DIW'(c);
                    ui = DIW'(r_row) + DIW'(c);
                    free_cols[c] = !r_col_taken[c] && !r_down_taken[di] && !r_up_taken[ui];
                end
            end
        end
    end

    assign lowest = free_cols & (~free_cols + MAX_SIZE'(1));

    always_comb begin
        sel_col = '0;
        for (int c = 0; c < MAX_SIZE; c++) begin
            if (lowest[c]) begin
                sel_col = sel_col | CW'(c);
            end
        end
    end

    // placing sets and lifting clears the same three bits: a toggle covers both
    assign toggle   = i_cmd.place || i_cmd.back_apply;
    assign tgl_col  = i_cmd.place ? sel_col : ram_rdata;
    assign tgl_down = DIW'(r_row) + DIW'(r_n) - DIW'(1) - DIW'(tgl_col);
    assign tgl_up   = DIW'(r_row) + DIW'(tgl_col);

    // after a step back r_row already names the row whose column is needed
    assign ram_raddr = i_cmd.emit_rd ? r_k : CW'(r_row);

    nqfs_ram #(
        .WIDTH (CW),
        .DEPTH (MAX_SIZE)
    ) u_col_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.place),
        .i_waddr (CW'(r_row)),
        .i_wdata (sel_col),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n          <= '0;
            r_row        <= '0;
            r_start      <= '0;
            r_k          <= '0;
            r_col_taken  <= '0;
            r_down_taken <= '0;
            r_up_taken   <= '0;
            o_valid      <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_n          <= RW'(i_board_size);
                r_row        <= '0;
                r_start      <= '0;
                r_k          <= '0;
                r_col_taken  <= '0;
                r_down_taken <= '0;
                r_up_taken   <= '0;
            end
            if (toggle) begin
                r_col_taken  <= r_col_taken ^ (MAX_SIZE'(1) << tgl_col);
                r_down_taken <= r_down_taken ^ (DW'(1) << tgl_down);
                r_up_taken   <= r_up_taken ^ (DW'(1) << tgl_up);
            end
            if (i_cmd.place) begin
                r_row   <= r_row + RW'(1);
                r_start <= '0;
            end
            if (i_cmd.back_rd) begin
                r_row <= r_row - RW'(1);
            end
            if (i_cmd.back_apply) begin
                r_start <= RW'(ram_rdata) + RW'(1);
            end
            if (i_cmd.emit_ld) begin
                r_k <= r_k + CW'(1);
            end
            if (i_cmd.emit_ld || i_cmd.load_fail) begin
                o_valid <= 1'b1;
            end else if (!i_stall) begin
                o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_fail) begin
            o_row_index <= '0;
            o_queen_col <= '0;
            o_solved    <= 1'b0;
            o_last      <= 1'b1;
        end else if (i_cmd.emit_ld) begin
            o_row_index <= OUT_W'(r_k);
            o_queen_col <= OUT_W'(ram_rdata);
            o_solved    <= 1'b1;
            o_last      <= o_stat.emit_last;
        end
    end

    assign o_stat.bad_size  = (i_board_size == '0) ||
                              (i_board_size > SIZE_W'(SIZE_LIMIT));
    assign o_stat.row_full  = (r_row == r_n);
    assign o_stat.row_zero  = (r_row == '0);
    assign o_stat.found     = |free_cols;
    assign o_stat.emit_last = ((RW'(r_k) + RW'(1)) == r_n);
    assign o_stat.out_free  = !o_valid || !i_stall;

endmodule

`default_nettype wire

// ===== design/n_queens_first_solution_search.sv =====
// N-queens first-solution search: top level joining controller and datapath.
// Depends on nqfs_pkg, nqfs_ctrl, nqfs_dp (and nqfs_ram below it).
//
// Usage:
//   Input channel (i_valid / o_stall / i_board_size): one item is a board
//   size. o_stall is high from acceptance until the last result item of the
//   search has been loaded into the output register.
//   Output channel (o_valid / i_stall / o_row_index, o_queen_col, o_solved,
//   o_last): a solved size n gives n items, row 0 first, o_last on row n-1.
//   Size 0, sizes above the limit, and sizes with no placement give one
//   item with o_solved low and o_last high.
//   In the search loop each tried placement is one scan step, and a
//   backtrack step passes through S_SCAN, S_BACK_RD and S_BACK (column
//   store read is registered); each result item passes through S_EMIT_RD
//   and S_EMIT. Out-of-range sizes go straight to the no-solution item.
//   A stalled output holds its item and the readout waits on it; the next
//   board size can be taken as soon as the last item sits in the output
//   register. Reset (synchronous, active low) returns to idle, clears the
//   masks and empties the output register.
`default_nettype none

module n_queens_first_solution_search
    import nqfs_pkg::*;
#(
    parameter int MAX_SIZE = MAX_SIZE_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [SIZE_W-1:0] i_board_size,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic      [OUT_W-1:0]  o_row_index,
    output logic      [OUT_W-1:0]  o_queen_col,
    output logic                   o_solved,
    output logic                   o_last
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;
    logic     busy;

    nqfs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd),
        .o_busy  (busy)
    );

    nqfs_dp #(
        .MAX_SIZE (MAX_SIZE)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_stat       (dp_stat),
        .i_board_size (i_board_size),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_row_index  (o_row_index),
        .o_queen_col  (o_queen_col),
        .o_solved     (o_solved),
        .o_last       (o_last)
    );

    assign o_stall = busy;

`ifndef SYNTHESIS
    // a result item is never loaded over one still waiting downstream
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (dp_cmd.emit_ld || dp_cmd.load_fail) |-> !(o_valid && i_stall))
        else $error("output register overwritten while stalled");

    // accepting a new size never coincides with loading a result item
    a_accept_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |-> !(dp_cmd.emit_ld || dp_cmd.load_fail))
        else $error("result load while taking a new item");

    // controller issues at most one datapath command per cycle
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(dp_cmd))
        else $error("conflicting datapath commands");

    // a final result item returns the block to idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (dp_cmd.load_fail || (dp_cmd.emit_ld && dp_stat.emit_last)) |=> !o_stall)
        else $error("block still busy after final result item");
`endif

endmodule

`default_nettype wire

// ===== sim/nqfs_checker.sv =====
// Scoreboard for the n-queens first-solution search: watches both channels,
// runs its own backtracking search per accepted board size and compares rows.
// Depends on nqfs_pkg.
`timescale 1ns / 1ps

module nqfs_checker
    import nqfs_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_in_stall,
    input  wire logic [SIZE_W-1:0] i_in_size,
    input  wire logic              i_out_valid,
    input  wire logic              i_out_stall,
    input  wire logic [OUT_W-1:0]  i_row_index,
    input  wire logic [OUT_W-1:0]  i_queen_col,
    input  wire logic              i_solved,
    input  wire logic              i_last,
    output int                     o_mismatches,
    output int                     o_rows_pending
);

    localparam int SIZE_CAP = (MAX_SIZE_DEF < RESULT_LIMIT) ? MAX_SIZE_DEF : RESULT_LIMIT;
    localparam int DIAG_W   = 2 * SIZE_CAP - 1;

    typedef struct packed {
        logic [OUT_W-1:0] row_index;
        logic [OUT_W-1:0] queen_col;
        logic             solved;
        logic             last;
    } row_result_t;

    row_result_t solution_rows[$];

    // Own copy of the search state
    logic [OUT_W-1:0]    col_of_row [SIZE_CAP];
    int                  depth;
    logic [SIZE_CAP-1:0] cols_used;
    logic [DIAG_W-1:0]   down_used;   // index row - col + n - 1
    logic [DIAG_W-1:0]   up_used;     // index row + col

    initial begin
        o_mismatches   = 0;
        o_rows_pending = 0;
    end

    function automatic bit square_free(input int r, input int c, input int n);
        return !cols_used[c] && !down_used[r + n - 1 - c] && !up_used[r + c];
    endfunction

    task automatic set_queen(input int r, input int c, input int n, input bit on);
        cols_used[c]             = on;
        down_used[r + n - 1 - c] = on;
        up_used[r + c]           = on;
    endtask

    task automatic find_first_placement(input int n, output bit ok);
        int  start;
        int  c;
        bit  hit;
        bit  done;
        depth     = 0;
        cols_used = '0;
        down_used = '0;
        up_used   = '0;
        start     = 0;
        ok        = 1'b0;
        done      = 1'b0;
        while (!done) begin
            if (depth == n) begin
                ok   = 1'b1;
                done = 1'b1;
            end else begin
                hit = 1'b0;
                c   = start;
                while (c < n && !hit) begin
                    if (square_free(depth, c, n))
                        hit = 1'b1;
                    else
                        c++;
                end
                if (hit) begin
                    col_of_row[depth] = c[OUT_W-1:0];
                    set_queen(depth, c, n, 1'b1);
                    depth++;
                    start = 0;
                end else if (depth == 0) begin
                    done = 1'b1;
                end else begin
                    depth--;
                    c = int'(col_of_row[depth]);
                    set_queen(depth, c, n, 1'b0);
                    start = c + 1;
                end
            end
        end
    endtask

    task automatic queue_rows(input logic [SIZE_W-1:0] size);
        int          n;
        int          r;
        bit          ok;
        row_result_t rec;
        n  = int'(size);
        ok = 1'b0;
        if (n != 0 && n <= SIZE_CAP)
            find_first_placement(n, ok);
        if (!ok) begin
            rec = '{row_index: '0, queen_col: '0, solved: 1'b0, last: 1'b1};
            solution_rows.push_back(rec);
        end else begin
            for (r = 0; r < n; r++) begin
                rec.row_index = r[OUT_W-1:0];
                rec.queen_col = col_of_row[r];
                rec.solved    = 1'b1;
                rec.last      = (r == n - 1);
                solution_rows.push_back(rec);
            end
        end
    endtask

    always @(posedge i_clk) begin : monitor
        row_result_t head;
        if (i_rst_n && i_out_valid && !i_out_stall) begin
            if (solution_rows.size() == 0) begin
                $error("unexpected result item: row %0d col %0d solved %0b last %0b",
                       i_row_index, i_queen_col, i_solved, i_last);
                o_mismatches = o_mismatches + 1;
            end else begin
                head = solution_rows.pop_front();
                if (i_row_index !== head.row_index) begin
                    $error("row_index: expected %0d, got %0d", head.row_index, i_row_index);
                    o_mismatches = o_mismatches + 1;
                end
                if (i_queen_col !== head.queen_col) begin
                    $error("queen_col: expected %0d, got %0d", head.queen_col, i_queen_col);
                    o_mismatches = o_mismatches + 1;
                end
                if (i_solved !== head.solved) begin
                    $error("solved: expected %0b, got %0b", head.solved, i_solved);
                    o_mismatches = o_mismatches + 1;
                end
                if (i_last !== head.last) begin
                    $error("last: expected %0b, got %0b", head.last, i_last);
                    o_mismatches = o_mismatches + 1;
                end
            end
        end
        if (i_rst_n && i_in_valid && !i_in_stall)
            queue_rows(i_in_size);
        o_rows_pending = solution_rows.size();
    end

endmodule

// ===== sim/tb_n_queens_first_solution_search.sv =====
// Testbench top for the n-queens first-solution search: clock, reset,
// board-size stimulus and output stall, with the verdict from nqfs_checker.
// Depends on nqfs_pkg, nqfs_checker and the design.
`timescale 1ns / 1ps

module tb_n_queens_first_solution_search;
    import nqfs_pkg::*;

    localparam int CYCLE_LIMIT  = 20_000_000;
    localparam int DRAIN_CYCLES = 64;

    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              i_valid      = 1'b0;
    logic              i_stall      = 1'b0;
    logic [SIZE_W-1:0] i_board_size = '0;
    logic              o_stall;
    logic              o_valid;
    logic [OUT_W-1:0]  o_row_index;
    logic [OUT_W-1:0]  o_queen_col;
    logic              o_solved;
    logic              o_last;

    int send_gap_pct = 25;
    int stall_pct    = 76;
    int cycle_count  = 0;
    int mismatches;
    int rows_pending;

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_stall <= 1'b0;
        else
            i_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    n_queens_first_solution_search u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_board_size (i_board_size),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_row_index  (o_row_index),
        .o_queen_col  (o_queen_col),
        .o_solved     (o_solved),
        .o_last       (o_last)
    );

    nqfs_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_stall     (o_stall),
        .i_in_size      (i_board_size),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_row_index    (o_row_index),
        .i_queen_col    (o_queen_col),
        .i_solved       (o_solved),
        .i_last         (o_last),
        .o_mismatches   (mismatches),
        .o_rows_pending (rows_pending)
    );

    // Called at a rising edge; returns at the edge where the item is taken.
    task automatic offer_size(input logic [SIZE_W-1:0] size);
        bit taken;
        while ($urandom_range(99) < send_gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_board_size <= size;
        taken = 1'b0;
        while (!taken) begin
            // o_stall only moves at rising edges, so the falling edge shows
            // the value the next rising edge will see
            @(negedge i_clk);
            taken = !o_stall;
            @(posedge i_clk);
        end
    endtask

    // Mostly cheap sizes; size 16 is slow and kept rare
    function automatic logic [SIZE_W-1:0] random_size();
        int pick;
        pick = $urandom_range(99);
        if (pick < 62)
            return SIZE_W'($urandom_range(12, 1));
        else if (pick < 82)
            return SIZE_W'($urandom_range(15, 13));
        else if (pick < 85)
            return SIZE_W'(16);
        else if (pick < 97)
            return SIZE_W'($urandom_range(31, 17));
        else
            return SIZE_W'(0);
    endfunction

    initial begin
        int k;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sizes 0..17 cover no-solution, smallest, largest and just past it
        for (k = 0; k <= 17; k++)
            offer_size(SIZE_W'(k));
        offer_size(SIZE_W'(24));
        offer_size(SIZE_W'(31));

        for (k = 0; k < 27; k++)
            offer_size(random_size());
        send_gap_pct = 76;
        stall_pct    = 25;
        for (k = 0; k < 27; k++)
            offer_size(random_size());
        send_gap_pct = 0;
        stall_pct    = 0;
        for (k = 0; k < 26; k++)
            offer_size(random_size());
        i_valid <= 1'b0;

        do
            @(negedge i_clk);
        while (rows_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
design/nqfs_pkg.sv
design/nqfs_ram.sv
design/nqfs_ctrl.sv
design/nqfs_dp.sv
design/n_queens_first_solution_search.sv
sim/nqfs_checker.sv
sim/tb_n_queens_first_solution_search.sv
